### rtl/move_to_front_transform_assert.svh
// assertion macros shared by the move-to-front transform
`ifndef MOVE_TO_FRONT_TRANSFORM_ASSERT_SVH
`define MOVE_TO_FRONT_TRANSFORM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MTF_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtf check failed");

// next-cycle implication, checked outside reset
`define MTF_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtf check failed");

`endif

### rtl/mtf_pkg.sv
// types and constants of the move-to-front transform
package mtf_pkg;

  localparam int unsigned SYM_W    = 8;
  localparam int unsigned GRP_SIZE = 16;

  // direction codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // control broadcast to every cell
  typedef struct packed {
    logic             load;   // capture a compare hit for a new transfer
    logic             dir;
    logic [SYM_W-1:0] sym;    // incoming byte, used at load
    logic             upd;    // apply the move to front
    logic             found;
    logic             last;
    logic [SYM_W-1:0] pos;    // rank of the moved symbol
  } mtf_cell_ctl_t;

  // result of one group of cells
  typedef struct packed {
    logic             hit;
    logic [SYM_W-1:0] pos;
    logic [SYM_W-1:0] val;
  } mtf_grp_t;

endpackage

### rtl/mtf_in_if.sv
// input channel: byte and end-of-buffer mark
interface mtf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sym_in;
  logic       last_in;

  modport source (output valid, output sym_in, output last_in, input ready);
  modport sink   (input valid, input sym_in, input last_in, output ready);
endinterface

### rtl/mtf_out_if.sv
// output channel: result byte and end-of-buffer mark
interface mtf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sym_out;
  logic       last_out;

  modport source (output valid, output sym_out, output last_out, input ready);
  modport sink   (input valid, input sym_out, input last_out, output ready);
endinterface

### rtl/move_to_front_transform.sv
// top level of the byte-wise move-to-front transform
//
//  channel   dir   payload              transfer when
//  in_ch     in    sym_in, last_in      in_ch.valid && in_ch.ready
//  out_ch    out   sym_out, last_out    out_ch.valid && out_ch.ready
//  cfg       in    cfg_wr_data (dir)    cfg_wr_en
//
// An item passes these steps in order: compare in every cell at the input transfer, then
// the group registers, then the final reduction registers, then the shift of the cells.
// One item is in the cell row at a time; the next is taken while a result waits in
// the output register. The table is the identity straight after reset, with no sweep.
// A stalled output holds the shift cycle until the result register frees up.
`include "move_to_front_transform_assert.svh"

module move_to_front_transform #(
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  logic      clk,
  input  logic      rst,
  mtf_in_if.sink    in_ch,
  mtf_out_if.source out_ch,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);
  import mtf_pkg::*;

  localparam int unsigned GROUPS = (ALPHABET_SIZE + GRP_SIZE - 1) / GRP_SIZE;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_GRP  = 4'b0010,
    S_RED  = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic                                  direction;
  logic                                  last_q;
  logic                                  in_fire;
  logic                                  out_free;
  logic                                  upd_fire;
  logic [ALPHABET_SIZE-1:0]              hit_vec;
  logic [ALPHABET_SIZE-1:0][SYM_W-1:0]   val_vec;
  logic [ALPHABET_SIZE-1:0][SYM_W-1:0]   prev_vec;
  mtf_grp_t [GROUPS-1:0]                 grp_res;
  mtf_grp_t                              red_next;
  logic                                  found_r;
  logic [SYM_W-1:0]                      pos_r;
  logic [SYM_W-1:0]                      front_r;
  mtf_cell_ctl_t                         ctl;
  logic                                  out_valid;
  logic [SYM_W-1:0]                      out_sym;
  logic                                  out_last;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign upd_fire = (state == S_UPD) && out_free;

  // direction register
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
    end else if (cfg_wr_en) begin
      direction <= cfg_wr_data;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_fire) state_next = S_GRP;
      S_GRP:   state_next = S_RED;
      S_RED:   state_next = S_UPD;
      S_UPD:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ch.ready = (state == S_IDLE);

  // end-of-buffer mark of the item in flight
  always_ff @(posedge clk) begin
    if (in_fire) begin
      last_q <= in_ch.last_in;
    end
  end

  // control broadcast to the cell row
  always_comb begin
    ctl       = '0;
    ctl.load  = in_fire;
    ctl.dir   = direction;
    ctl.sym   = in_ch.sym_in;
    ctl.upd   = upd_fire;
    ctl.found = found_r;
    ctl.last  = last_q;
    ctl.pos   = pos_r;
  end

  // row of cells, each fed by its lower neighbour; the front takes the moved symbol
  for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
    if (k == 0) begin : g_front
      assign prev_vec[k] = front_r;
    end else begin : g_rest
      assign prev_vec[k] = val_vec[k-1];
    end
    mtf_cell #(.IDX(k)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .prev  (prev_vec[k]),
      .value (val_vec[k]),
      .hit   (hit_vec[k])
    );
  end

  // first level of the hit reduction
  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    localparam int unsigned BASE = g * GRP_SIZE;
    localparam int unsigned CNT  =
      (ALPHABET_SIZE - BASE < GRP_SIZE) ? (ALPHABET_SIZE - BASE) : GRP_SIZE;
    mtf_grp #(.COUNT(CNT), .BASE(BASE)) u_grp (
      .clk  (clk),
      .hits (hit_vec[BASE +: CNT]),
      .vals (val_vec[BASE +: CNT]),
      .res  (grp_res[g])
    );
  end

  // final level of the hit reduction
  always_comb begin
    red_next = '0;
    for (int unsigned g = 0; g < GROUPS; g++) begin
      red_next.hit = red_next.hit | grp_res[g].hit;
      red_next.pos = red_next.pos | grp_res[g].pos;
      red_next.val = red_next.val | grp_res[g].val;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= red_next.hit;
    pos_r   <= red_next.pos;
    front_r <= red_next.val;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_sym  <= (direction == DIR_DECODE) ? front_r : pos_r;
      out_last <= last_q;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.sym_out  = out_sym;
  assign out_ch.last_out = out_last;

  // checks
  `MTF_ASSERT_NEXT(a_accept_starts, clk, rst, in_fire, state == S_GRP)
  `MTF_ASSERT_SAME(a_single_hit, clk, rst, state == S_RED, $onehot0(hit_vec))
  `MTF_ASSERT_NEXT(a_miss_gives_zero, clk, rst, upd_fire && !found_r,
                   out_ch.valid && (out_ch.sym_out == '0))

endmodule

### rtl/mtf_cell.sv
// one entry of the recency table with its compare and shift logic
module mtf_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mtf_pkg::mtf_cell_ctl_t       ctl,
  input  logic [mtf_pkg::SYM_W-1:0]    prev,
  output logic [mtf_pkg::SYM_W-1:0]    value,
  output logic                         hit
);
  import mtf_pkg::*;

  localparam logic [SYM_W-1:0] IDX_B = SYM_W'(IDX);

  // entry and hit flag; a last byte resets the entry, else entries at or before the moved rank take prev
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= IDX_B;
      hit   <= 1'b0;
    end else begin
      if (ctl.load) begin
        hit <= (ctl.dir == DIR_DECODE) ? (IDX_B == ctl.sym) : (value == ctl.sym);
      end
      if (ctl.upd) begin
        if (ctl.last) begin
          value <= IDX_B;
        end else if (ctl.found && (IDX_B <= ctl.pos)) begin
          value <= prev;
        end
      end
    end
  end

endmodule

### rtl/mtf_grp.sv
// registered or-reduction of the hits of one group of cells
module mtf_grp #(
  parameter int unsigned COUNT = 16,
  parameter int unsigned BASE  = 0
) (
  input  logic                                 clk,
  input  logic [COUNT-1:0]                     hits,
  input  logic [COUNT-1:0][mtf_pkg::SYM_W-1:0] vals,
  output mtf_pkg::mtf_grp_t                    res
);
  import mtf_pkg::*;

  mtf_grp_t acc;

  // at most one hit in the group, so an or gives its rank and symbol
  always_comb begin
    acc = '0;
    for (int unsigned i = 0; i < COUNT; i++) begin
      if (hits[i]) begin
        acc.hit = 1'b1;
        acc.pos = acc.pos | SYM_W'(BASE + i);
        acc.val = acc.val | vals[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= acc;
  end

endmodule

### tb/tb_move_to_front_transform.sv
// self-checking testbench for the byte-wise move-to-front transform
`timescale 1ns / 1ps

module tb_move_to_front_transform;
  import mtf_pkg::*;

  localparam int ALPHABET = 256;

  typedef struct packed {
    logic       dir;
    logic [7:0] sym;
    logic       last;
    logic       fixed;    // expected byte typed in below
    logic [7:0] exp_sym;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
  } mtf_result_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  mtf_in_if  in_if ();
  mtf_out_if out_if ();

  // recency table and direction as the block should hold them
  logic [7:0]  rank_table [ALPHABET];
  logic        dir_q;
  mtf_result_t pending_results [$];

  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  int bytes_sent;
  int encode_bytes;
  int decode_bytes;
  int buffers_closed;
  int results_checked;

  // directed bytes: extremes, both directions, last marks, switches mid-buffer
  stim_row_t directed_rows [0:21] = '{
    '{DIR_ENCODE, 8'd0,   1'b0, 1'b1, 8'd0},
    '{DIR_ENCODE, 8'd255, 1'b0, 1'b1, 8'd255},
    '{DIR_ENCODE, 8'd255, 1'b0, 1'b1, 8'd0},
    '{DIR_ENCODE, 8'd0,   1'b0, 1'b1, 8'd1},
    '{DIR_ENCODE, 8'd128, 1'b1, 1'b0, 8'd0},
    '{DIR_ENCODE, 8'd200, 1'b0, 1'b1, 8'd200},
    '{DIR_ENCODE, 8'd200, 1'b1, 1'b1, 8'd0},
    '{DIR_DECODE, 8'd0,   1'b0, 1'b1, 8'd0},
    '{DIR_DECODE, 8'd255, 1'b0, 1'b1, 8'd255},
    '{DIR_DECODE, 8'd0,   1'b0, 1'b1, 8'd255},
    '{DIR_DECODE, 8'd1,   1'b0, 1'b1, 8'd0},
    '{DIR_DECODE, 8'd170, 1'b0, 1'b0, 8'd0},
    '{DIR_DECODE, 8'd85,  1'b1, 1'b0, 8'd0},
    '{DIR_DECODE, 8'd37,  1'b1, 1'b1, 8'd37},
    '{DIR_DECODE, 8'd10,  1'b0, 1'b1, 8'd10},
    '{DIR_ENCODE, 8'd10,  1'b0, 1'b1, 8'd0},
    '{DIR_ENCODE, 8'd0,   1'b0, 1'b1, 8'd1},
    '{DIR_ENCODE, 8'd85,  1'b0, 1'b0, 8'd0},
    '{DIR_DECODE, 8'd2,   1'b0, 1'b0, 8'd0},
    '{DIR_DECODE, 8'd255, 1'b1, 1'b0, 8'd0},
    '{DIR_ENCODE, 8'h55,  1'b0, 1'b1, 8'h55},
    '{DIR_ENCODE, 8'hAA,  1'b1, 1'b1, 8'hAA}
  };

  move_to_front_transform #(
    .ALPHABET_SIZE(ALPHABET)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // table back to the identity
  function automatic void identity_table();
    for (int k = 0; k < ALPHABET; k++) begin
      rank_table[k] = 8'(k);
    end
  endfunction

  // rank or symbol for one byte, then move the symbol to the front; a last byte resets the table
  function automatic logic [7:0] mtf_step(input logic [7:0] sym, input logic last);
    int         pos;
    bit         hit;
    logic [7:0] moved;
    logic [7:0] res;
    pos = 0;
    hit = 1'b0;
    res = 8'd0;
    if (dir_q == DIR_ENCODE) begin
      for (int k = 0; k < ALPHABET; k++) begin
        if (!hit && rank_table[k] == sym) begin
          hit = 1'b1;
          pos = k;
        end
      end
    end else if (int'(sym) < ALPHABET) begin
      hit = 1'b1;
      pos = int'(sym);
    end
    // a byte outside the alphabet leaves the table alone and yields 0
    if (hit) begin
      moved = rank_table[pos];
      res   = (dir_q == DIR_ENCODE) ? 8'(pos) : moved;
      for (int k = pos; k > 0; k--) begin
        rank_table[k] = rank_table[k-1];
      end
      rank_table[0] = moved;
    end
    if (last) begin
      identity_table();
    end
    return res;
  endfunction

  // one input transfer, with random gaps ahead of it; called at a falling edge
  task automatic send_byte(input logic [7:0] sym, input logic last,
                           input logic fixed, input logic [7:0] exp_sym);
    mtf_result_t exp_res;
    logic [7:0]  predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.sym_in  <= sym;
    in_if.last_in <= last;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    predicted    = mtf_step(sym, last);
    exp_res.sym  = fixed ? exp_sym : predicted;
    exp_res.last = last;
    pending_results.push_back(exp_res);
    bytes_sent++;
    if (dir_q == DIR_ENCODE) encode_bytes++;
    else decode_bytes++;
    if (last) buffers_closed++;
    @(negedge clk);
  endtask

  // hold the sender until every result is back and the cells have settled
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // direction write, only while the block is idle
  task automatic write_direction(input logic dir);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= dir;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    dir_q = dir;
  endtask

  // random buffers in one direction: local palettes keep ranks small and shifts shallow
  task automatic run_segment(input logic dir, input int n_bytes);
    int         sent;
    int         blen;
    int         k;
    int         pick;
    logic [7:0] palette [8];
    logic [7:0] sym;
    logic       last;
    wait_drained();
    write_direction(dir);
    sent = 0;
    while (sent < n_bytes) begin
      blen = ($urandom_range(0, 15) == 0) ? $urandom_range(200, 400) : $urandom_range(1, 40);
      for (int p = 0; p < 8; p++) begin
        palette[p] = 8'($urandom_range(0, 255));
      end
      for (k = 0; k < blen && sent < n_bytes; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          sym = (dir == DIR_ENCODE) ? palette[$urandom_range(0, 7)] : 8'($urandom_range(0, 7));
        end else if (pick < 8) begin
          sym = 8'($urandom_range(0, 255));
        end else if (pick == 8) begin
          sym = 8'd0;
        end else begin
          sym = 8'd255;
        end
        // stray last marks break a buffer early
        last = (k == blen - 1) || ($urandom_range(0, 199) == 0);
        if ($urandom_range(0, 299) == 0) begin
          wait_drained();
        end
        send_byte(sym, last, 1'b0, 8'd0);
        sent++;
      end
    end
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // compare each output transfer with the oldest expectation
  always @(posedge clk) begin
    mtf_result_t exp_res;
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("sym_out: unexpected transfer, got %0d", out_if.sym_out);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        results_checked++;
        if (out_if.sym_out !== exp_res.sym) begin
          $error("sym_out: expected %0d, actual %0d", exp_res.sym, out_if.sym_out);
          errors++;
        end
        if (out_if.last_out !== exp_res.last) begin
          $error("last_out: expected %0d, actual %0d", exp_res.last, out_if.last_out);
          errors++;
        end
      end
    end
  end

  // main sequence
  initial begin
    rst            = 1'b1;
    in_if.valid    = 1'b0;
    in_if.sym_in   = 8'd0;
    in_if.last_in  = 1'b0;
    out_if.ready   = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = DIR_ENCODE;
    errors         = 0;
    bytes_sent     = 0;
    encode_bytes   = 0;
    decode_bytes   = 0;
    buffers_closed = 0;
    results_checked = 0;
    send_idle_pct  = 31;
    recv_idle_pct  = 56;
    dir_q          = DIR_ENCODE;
    identity_table();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_direction(DIR_ENCODE);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].dir != dir_q) begin
        wait_drained();
        write_direction(directed_rows[i].dir);
      end
      send_byte(directed_rows[i].sym, directed_rows[i].last,
                directed_rows[i].fixed, directed_rows[i].exp_sym);
    end

    // random buffers: sender-light, receiver-light, then no idling
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 56 : 0;
      recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 31 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        run_segment(((seg + ph) % 2 == 1) ? DIR_DECODE : DIR_ENCODE, 170);
      end
    end

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d bytes (%0d encode, %0d decode) in %0d closed buffers",
             bytes_sent, encode_bytes, decode_bytes, buffers_closed);
    $display("checked %0d results across both stall mixes and a stall-free stretch",
             results_checked);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/mtf_pkg.sv
rtl/mtf_in_if.sv
rtl/mtf_out_if.sv
rtl/mtf_cell.sv
rtl/mtf_grp.sv
rtl/move_to_front_transform.sv
tb/tb_move_to_front_transform.sv
